[hdl/sspf_pkg.sv]
// Shared constants and types for the servo status frame parser.
// No dependencies.
`timescale 1ns / 1ps

package sspf_pkg;

	localparam int FRAME_BYTES    = 8;
	localparam int POS_W          = $clog2(FRAME_BYTES);
	localparam int BYTE_W         = 8;
	localparam int WORD_W         = 2 * BYTE_W;

	localparam logic [BYTE_W-1:0] HEADER_MARK    = 8'hFF;
	localparam logic [POS_W-1:0]  FIRST_SUMMED   = POS_W'(2);
	localparam logic [POS_W-1:0]  PARAM_LOW_POS  = POS_W'(5);
	localparam logic [POS_W-1:0]  PARAM_HIGH_POS = POS_W'(6);
	localparam logic [POS_W-1:0]  LAST_POS       = POS_W'(FRAME_BYTES - 1);

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_MISMATCH = 1'b1;

	typedef struct packed {
		logic                     fire;
		logic                     status;
		logic signed [WORD_W-1:0] word;
	} sspf_result_t;

endpackage

[hdl/sspf_frame_core.sv]
// Frame position tracker, running checksum and parameter capture.
// Depends on sspf_pkg.
`timescale 1ns / 1ps

module sspf_frame_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [sspf_pkg::BYTE_W-1:0]  rx_byte,
	output sspf_pkg::sspf_result_t       result
);
	import sspf_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] plo_q;
	logic [BYTE_W-1:0] phi_q;

	logic              at_last;
	logic              mismatch;

	assign at_last  = (pos_q == LAST_POS);
	assign mismatch = (~sum_q != rx_byte);

	always_comb begin
		result.fire   = at_last;
		result.status = mismatch ? STATUS_MISMATCH : STATUS_OK;
		result.word   = mismatch ? '0 : $signed({phi_q, plo_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			plo_q <= '0;
			phi_q <= '0;
		end else if (step) begin
			if (pos_q == '0) begin
				if (rx_byte == HEADER_MARK) begin
					sum_q <= '0;
					pos_q <= POS_W'(1);
				end
			end else if (at_last) begin
				pos_q <= '0;
			end else begin
				if (pos_q >= FIRST_SUMMED) begin
					sum_q <= sum_q + rx_byte;
					if (pos_q == PARAM_LOW_POS)
						plo_q <= rx_byte;
					else if (pos_q == PARAM_HIGH_POS)
						phi_q <= rx_byte;
				end
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

[hdl/servo_status_frame_parser.sv]
// Throughput: one byte per cycle, unless a checksum byte waits for the result register to be free.
// An input register and a result register part the two sides.
// Reset clears both valid flags and the frame position, sum and parameters.
// Top level of the servo status frame parser. Depends on sspf_pkg and sspf_frame_core.
`timescale 1ns / 1ps

module servo_status_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [0] frame_status, [16:1] word_value, [23:17] zero
);
	import sspf_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_free;
	logic              advance;
	sspf_result_t      res;

	logic              status_q;
	logic [WORD_W-1:0] word_q;

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign advance       = valid_s1 && (!res.fire || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			byte_s1 <= s_axis_tdata;
	end

	sspf_frame_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= advance && res.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res.fire) begin
			status_q <= res.status;
			word_q   <= res.word;
		end
	end

	assign m_axis_tdata = {7'd0, word_q, status_q};

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input stage overwritten before processing");

	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.fire |-> out_free)
		else $error("result produced with output register occupied");

	a_mismatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[16:1] == 16'd0)
		else $error("mismatch result carries a non-zero word");
`endif

endmodule

[sim/tb_servo_status_frame_parser.sv]
// Self-checking testbench for servo_status_frame_parser: drives received bytes on the
// slave stream and checks each status transaction against an in-bench frame predictor.
// Depends on sspf_pkg and the servo_status_frame_parser RTL.
`timescale 1ns / 1ps

module tb_servo_status_frame_parser;
	import sspf_pkg::*;

	localparam int          CLK_PERIOD   = 10;
	localparam int          RESET_CYCLES = 8;
	localparam int          LONG_HOLD    = 300;
	localparam int          DRAIN_CYCLES = 12;
	localparam int          RANDOM_BYTES = 900;
	localparam int unsigned CYCLE_LIMIT  = 400_000;

	typedef struct packed {
		logic                     status;
		logic signed [WORD_W-1:0] word;
	} frame_result_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;

	frame_result_t pending_results[$];
	int unsigned   fail_count      = 0;
	int unsigned   cycle_count     = 0;
	int unsigned   bytes_in_frames = 0;
	bit            src_gaps        = 1'b0;
	bit            sink_gaps       = 1'b0;
	bit            hold_req        = 1'b0;

	// predictor state
	logic [POS_W-1:0]  frame_pos = '0;
	logic [BYTE_W-1:0] csum_acc  = '0;
	logic [BYTE_W-1:0] param_lo  = '0;
	logic [BYTE_W-1:0] param_hi  = '0;

	servo_status_frame_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever begin
			#(CLK_PERIOD / 2) clk = ~clk;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("servo_status_frame_parser test failed");
		$finish;
	end

	function automatic int unsigned rand_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] rand_byte_edge();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 8'h00;
		if (r < 20)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Advances the frame predictor by one received byte; queues a status on the checksum byte.
	function automatic void parse_rx_byte(input logic [7:0] rx);
		frame_result_t     res;
		logic [BYTE_W-1:0] want_csum;
		if (frame_pos == '0) begin
			if (rx == HEADER_MARK) begin
				csum_acc  = '0;
				frame_pos = POS_W'(1);
				bytes_in_frames++;
			end
		end else if (frame_pos == LAST_POS) begin
			want_csum = ~csum_acc;
			frame_pos = '0;
			bytes_in_frames++;
			if (want_csum == rx) begin
				res.status = STATUS_OK;
				res.word   = {param_hi, param_lo};
			end else begin
				res.status = STATUS_MISMATCH;
				res.word   = '0;
			end
			pending_results.push_back(res);
		end else begin
			if (frame_pos >= FIRST_SUMMED) begin
				csum_acc = csum_acc + rx;
				if (frame_pos == PARAM_LOW_POS)
					param_lo = rx;
				else if (frame_pos == PARAM_HIGH_POS)
					param_hi = rx;
			end
			frame_pos = frame_pos + POS_W'(1);
			bytes_in_frames++;
		end
	endfunction

	task automatic send_rx_byte(input logic [7:0] rx);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (rand_gap()) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= rx;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		parse_rx_byte(rx);
	endtask

	task automatic send_frame(input logic [7:0] hdr2, input logic [7:0] id, input logic [7:0] len,
			input logic [7:0] err, input logic [7:0] lo, input logic [7:0] hi, input bit corrupt);
		logic [7:0] csum;
		csum = ~(id + len + err + lo + hi);
		if (corrupt)
			csum = csum ^ 8'($urandom_range(1, 255));
		send_rx_byte(HEADER_MARK);
		send_rx_byte(hdr2);
		send_rx_byte(id);
		send_rx_byte(len);
		send_rx_byte(err);
		send_rx_byte(lo);
		send_rx_byte(hi);
		send_rx_byte(csum);
	endtask

	// sink side: random stalls, plus one long hold on request
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				hold_left = rand_gap() - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		frame_result_t want_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected status transaction: tdata=%h", m_axis_tdata);
				fail_count++;
			end else begin
				want_res = pending_results.pop_front();
				if (m_axis_tdata[0] !== want_res.status) begin
					$error("frame_status: expected %0d, got %0d", want_res.status,
						m_axis_tdata[0]);
					fail_count++;
				end
				if (m_axis_tdata[16:1] !== want_res.word) begin
					$error("word_value: expected %0d, got %0d", want_res.word,
						$signed(m_axis_tdata[16:1]));
					fail_count++;
				end
				if (m_axis_tdata[23:17] !== '0) begin
					$error("tdata padding: expected 0, got %h", m_axis_tdata[23:17]);
					fail_count++;
				end
			end
		end
	end

	// dropped first byte, arbitrary second header, extreme words, mismatch, sum wrap
	task automatic test_directed_frames();
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		send_rx_byte(8'hFE);
		send_frame(8'h00, 8'h01, 8'h04, 8'h00, 8'hFF, 8'h7F, 1'b0);
		send_frame(8'hA5, 8'hFE, 8'hFF, 8'hFF, 8'h00, 8'h80, 1'b1);
		send_frame(8'hFF, 8'hFE, 8'hFF, 8'hFF, 8'h00, 8'h80, 1'b0);
	endtask

	// mostly well-formed frames; some corrupt checksums, truncated frames and line noise
	task automatic test_random_stream();
		int unsigned start_bytes;
		int unsigned r;
		int unsigned n;
		start_bytes = bytes_in_frames;
		src_gaps    = 1'b1;
		sink_gaps   = 1'b1;
		while (bytes_in_frames - start_bytes < RANDOM_BYTES) begin
			if ($urandom_range(0, 24) == 0) begin
				src_gaps  = 1'($urandom_range(0, 1));
				sink_gaps = 1'($urandom_range(0, 1));
			end
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_frame(8'($urandom_range(0, 255)), rand_byte_edge(), rand_byte_edge(),
					rand_byte_edge(), rand_byte_edge(), rand_byte_edge(),
					$urandom_range(0, 4) == 0);
			end else if (r < 88) begin
				n = $urandom_range(1, 6);
				send_rx_byte(HEADER_MARK);
				repeat (n) send_rx_byte(8'($urandom_range(0, 255)));
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) send_rx_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// output held off for a long stretch while good frames keep coming
	task automatic test_output_backpressure();
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		hold_req  = 1'b1;
		repeat (12)
			send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
		sink_gaps = 1'b1;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_random_stream();
		test_output_backpressure();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("servo_status_frame_parser test passed");
		else
			$display("servo_status_frame_parser test failed");
		$finish;
	end

endmodule

[sim.f]
hdl/sspf_pkg.sv
hdl/sspf_frame_core.sv
hdl/servo_status_frame_parser.sv
sim/tb_servo_status_frame_parser.sv
